FILE: rtl/core/gtm_pkg.sv
// ----------------------------------------------------------------------------
// gtm_pkg
// Shared widths, constants, types and the sample scaling function of the
// gyro to mouse report block.
// ----------------------------------------------------------------------------
package gtm_pkg;

    // Field widths
    localparam int SAMPLE_W    = 8;
    localparam int MOVE_W      = 8;
    localparam int BTN_W       = 2;
    localparam int DEADBAND_W  = 4;
    localparam int OFFSET_W    = 8;
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_IDX_W   = 1;

    localparam int SAMPLE_MAX      = 255;
    localparam int CAL_SAMPLES_DEF = 16;

    localparam logic [DEADBAND_W-1:0] DEADBAND_RESET     = DEADBAND_W'(2);
    localparam logic [OFFSET_W-1:0]   CURVE_OFFSET_RESET = OFFSET_W'(37);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADBAND     = 1'b0,
        CFG_CURVE_OFFSET = 1'b1
    } t_cfg_index;

    typedef enum logic {
        PHASE_MOTION = 1'b0,
        PHASE_NULL   = 1'b1
    } t_phase;

    typedef struct packed {
        logic [BTN_W-1:0]         buttons;
        logic signed [MOVE_W-1:0] move_x;
        logic signed [MOVE_W-1:0] move_y;
    } t_motion;

    // Scaling v*255/171 == v*85/57, done as a multiply by a rounded-up
    // reciprocal of 57 folded together with 85.
    localparam int ScaleNum      = 85;
    localparam int ScaleDen      = 57;
    localparam int SCALE_SHIFT   = 21;
    localparam int SCALE_MUL     = ScaleNum * (((1 << SCALE_SHIFT) + ScaleDen - 1) / ScaleDen);
    localparam int SCALE_PROD_W  = SAMPLE_W + 22;
    localparam int SCALE_QUO_W   = SAMPLE_W + 1;

    // Acceleration curve
    localparam int GAIN_W        = 10;
    localparam int PROD_W        = SAMPLE_W + GAIN_W;
    // Divide by 80: shift by 4, then divide by 5 through a reciprocal
    localparam int DIV_PRE_SHIFT = 4;
    localparam int Div5Den       = 5;
    localparam int DIV5_SHIFT    = 16;
    localparam int DIV5_MUL      = ((1 << DIV5_SHIFT) + Div5Den - 1) / Div5Den;
    localparam int QIN_W         = PROD_W - DIV_PRE_SHIFT;
    localparam int QMUL_W        = 28;
    localparam int QUO_W         = 11;
    localparam int MOVE_POS_LIM  = 127;
    localparam int MOVE_NEG_LIM  = 128;

    localparam logic signed [MOVE_W-1:0] MOVE_POS_SAT = {1'b0, {(MOVE_W-1){1'b1}}};
    localparam logic signed [MOVE_W-1:0] MOVE_NEG_SAT = {1'b1, {(MOVE_W-1){1'b0}}};

    function automatic logic [SAMPLE_W-1:0] scale_sample(input logic [SAMPLE_W-1:0] v);
        logic [SCALE_PROD_W-1:0] prod;
        logic [SCALE_QUO_W-1:0]  quo;
        prod = SCALE_PROD_W'(v) * SCALE_PROD_W'(SCALE_MUL);
        quo  = prod[SCALE_SHIFT +: SCALE_QUO_W];
        // saturate readings above full scale
        return (quo > SCALE_QUO_W'(SAMPLE_MAX)) ? {SAMPLE_W{1'b1}} : quo[SAMPLE_W-1:0];
    endfunction

endpackage

FILE: rtl/core/gtm_sample_if.sv
// ----------------------------------------------------------------------------
// gtm_sample_if
// Valid/ready channel carrying one raw gyro sample and the button pins.
// ----------------------------------------------------------------------------
interface gtm_sample_if;
    import gtm_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] x_sample;
    logic [SAMPLE_W-1:0] y_sample;
    logic                left_pin;
    logic                right_pin;

    modport source (output valid, x_sample, y_sample, left_pin, right_pin, input ready);
    modport sink   (input valid, x_sample, y_sample, left_pin, right_pin, output ready);
endinterface

FILE: rtl/core/gtm_report_if.sv
// ----------------------------------------------------------------------------
// gtm_report_if
// Valid/ready channel carrying one mouse report.
// ----------------------------------------------------------------------------
interface gtm_report_if;
    import gtm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [BTN_W-1:0]         buttons;
    logic signed [MOVE_W-1:0] move_x;
    logic signed [MOVE_W-1:0] move_y;
    logic                     last;

    modport source (output valid, buttons, move_x, move_y, last, input ready);
    modport sink   (input valid, buttons, move_x, move_y, last, output ready);
endinterface

FILE: rtl/core/gtm_calib.sv
// ----------------------------------------------------------------------------
// gtm_calib
// Sums the first CAL_SAMPLES scaled samples per axis and loads the averaged
// baselines in the cycle after the last of them is taken.
// ----------------------------------------------------------------------------
module gtm_calib #(
    parameter int CAL_SAMPLES = gtm_pkg::CAL_SAMPLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [gtm_pkg::SAMPLE_W-1:0]  i_x_scaled,
    input  logic [gtm_pkg::SAMPLE_W-1:0]  i_y_scaled,
    output logic                          o_cal_done,
    output logic [gtm_pkg::SAMPLE_W-1:0]  o_x_baseline,
    output logic [gtm_pkg::SAMPLE_W-1:0]  o_y_baseline
);
    import gtm_pkg::*;

    localparam int CNT_W     = $clog2(CAL_SAMPLES + 1);
    localparam int ACC_W     = $clog2(SAMPLE_MAX * CAL_SAMPLES + 1);
    localparam int DIV_SHIFT = ACC_W + $clog2(CAL_SAMPLES);
    localparam longint unsigned RECIP =
        ((64'd1 << DIV_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
    localparam int RECIP_W   = ACC_W + 1;
    localparam int MUL_W     = ACC_W + RECIP_W;

    logic [CNT_W-1:0]    r_count;
    logic [ACC_W-1:0]    r_x_acc;
    logic [ACC_W-1:0]    r_y_acc;
    logic                r_base_ld;
    logic [SAMPLE_W-1:0] r_x_base;
    logic [SAMPLE_W-1:0] r_y_base;

    logic                w_take;
    logic [MUL_W-1:0]    w_x_prod;
    logic [MUL_W-1:0]    w_y_prod;

    assign o_cal_done = (r_count == CNT_W'(CAL_SAMPLES));
    assign w_take     = i_accept && !o_cal_done;

    // floor(sum / CAL_SAMPLES) through a rounded-up reciprocal
    assign w_x_prod = MUL_W'(r_x_acc) * MUL_W'(RECIP_W'(RECIP));
    assign w_y_prod = MUL_W'(r_y_acc) * MUL_W'(RECIP_W'(RECIP));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_x_acc   <= '0;
            r_y_acc   <= '0;
            r_base_ld <= 1'b0;
            r_x_base  <= '0;
            r_y_base  <= '0;
        end else begin
            r_base_ld <= w_take && (r_count == CNT_W'(CAL_SAMPLES - 1));
            if (w_take) begin
                r_count <= r_count + CNT_W'(1);
                r_x_acc <= r_x_acc + ACC_W'(i_x_scaled);
                r_y_acc <= r_y_acc + ACC_W'(i_y_scaled);
            end
            if (r_base_ld) begin
                r_x_base <= w_x_prod[DIV_SHIFT +: SAMPLE_W];
                r_y_base <= w_y_prod[DIV_SHIFT +: SAMPLE_W];
            end
        end
    end

    assign o_x_baseline = r_x_base;
    assign o_y_baseline = r_y_base;

endmodule

FILE: rtl/core/gtm_axis_curve.sv
// ----------------------------------------------------------------------------
// gtm_axis_curve
// One motion axis: delta, deadband and gain product are registered, then
// the product is divided by 80 and saturated to a signed byte.
// ----------------------------------------------------------------------------
module gtm_axis_curve (
    input  logic                                i_clk,
    input  logic                                i_ld,
    input  logic [gtm_pkg::SAMPLE_W-1:0]        i_minuend,
    input  logic [gtm_pkg::SAMPLE_W-1:0]        i_subtrahend,
    input  logic [gtm_pkg::DEADBAND_W-1:0]      i_deadband,
    input  logic [gtm_pkg::OFFSET_W-1:0]        i_curve_offset,
    output logic signed [gtm_pkg::MOVE_W-1:0]   o_move
);
    import gtm_pkg::*;

    logic [SAMPLE_W:0]   w_delta;
    logic [SAMPLE_W:0]   w_abs;
    logic                w_neg;
    logic [SAMPLE_W-1:0] w_mag;
    logic                w_dead;
    logic [GAIN_W-1:0]   w_tri;
    logic [GAIN_W-1:0]   w_gain;
    logic [PROD_W-1:0]   w_prod;

    logic [PROD_W-1:0]   r_prod;
    logic                r_neg;
    logic                r_dead;

    logic [QIN_W-1:0]    w_qin;
    logic [QMUL_W-1:0]   w_qmul;
    logic [QUO_W-1:0]    w_quo;
    logic [MOVE_W-1:0]   w_low;
    logic [MOVE_W-1:0]   w_low_neg;

    assign w_delta = {1'b0, i_minuend} - {1'b0, i_subtrahend};
    assign w_neg   = w_delta[SAMPLE_W];
    assign w_abs   = w_neg ? (~w_delta + (SAMPLE_W+1)'(1)) : w_delta;
    assign w_mag   = w_abs[SAMPLE_W-1:0];
    assign w_dead  = ({{(SAMPLE_W-DEADBAND_W){1'b0}}, i_deadband} >= w_mag);

    // gain = floor(3*|d|/2) + offset
    assign w_tri  = {2'b00, w_mag} + {1'b0, w_mag, 1'b0};
    assign w_gain = GAIN_W'(w_tri[GAIN_W-1:1]) + GAIN_W'(i_curve_offset);
    assign w_prod = PROD_W'(w_mag) * PROD_W'(w_gain);

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_prod <= w_prod;
            r_neg  <= w_neg;
            r_dead <= w_dead;
        end
    end

    // magnitude / 80, sign applied afterward gives truncation toward zero
    assign w_qin     = r_prod[PROD_W-1:DIV_PRE_SHIFT];
    assign w_qmul    = QMUL_W'(w_qin) * QMUL_W'(DIV5_MUL);
    assign w_quo     = w_qmul[DIV5_SHIFT +: QUO_W];
    assign w_low     = w_quo[MOVE_W-1:0];
    assign w_low_neg = ~w_low + MOVE_W'(1);

    always_comb begin
        if (r_dead) begin
            o_move = '0;
        end else if (r_neg) begin
            o_move = (w_quo > QUO_W'(MOVE_NEG_LIM)) ? MOVE_NEG_SAT : $signed(w_low_neg);
        end else begin
            o_move = (w_quo > QUO_W'(MOVE_POS_LIM)) ? MOVE_POS_SAT : $signed(w_low);
        end
    end

endmodule

FILE: rtl/core/gtm_report.sv
// ----------------------------------------------------------------------------
// gtm_report
// Output register: emits the motion report of an item, then its null
// report, and releases the item after the second one is loaded.
// ----------------------------------------------------------------------------
module gtm_report (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  gtm_pkg::t_motion i_motion,
    output logic             o_take,
    gtm_report_if.source     o_report
);
    import gtm_pkg::*;

    t_phase                   r_phase;
    t_phase                   n_phase;
    logic                     r_ov;
    logic [BTN_W-1:0]         r_buttons;
    logic signed [MOVE_W-1:0] r_move_x;
    logic signed [MOVE_W-1:0] r_move_y;
    logic                     r_last;

    logic [BTN_W-1:0]         n_buttons;
    logic signed [MOVE_W-1:0] n_move_x;
    logic signed [MOVE_W-1:0] n_move_y;
    logic                     n_last;
    logic                     w_load;

    assign w_load = i_valid && (!r_ov || o_report.ready);
    assign o_take = w_load && (r_phase == PHASE_NULL);

    always_comb begin
        n_phase = r_phase;
        if (w_load) begin
            unique case (r_phase)
                PHASE_MOTION: n_phase = PHASE_NULL;
                PHASE_NULL:   n_phase = PHASE_MOTION;
            endcase
        end
    end

    always_comb begin
        n_buttons = i_motion.buttons;
        unique case (r_phase)
            PHASE_MOTION: begin
                n_move_x = i_motion.move_x;
                n_move_y = i_motion.move_y;
                n_last   = 1'b0;
            end
            PHASE_NULL: begin
                n_move_x = '0;
                n_move_y = '0;
                n_last   = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PHASE_MOTION;
            r_ov    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_report.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_buttons <= n_buttons;
            r_move_x  <= n_move_x;
            r_move_y  <= n_move_y;
            r_last    <= n_last;
        end
    end

    assign o_report.valid   = r_ov;
    assign o_report.buttons = r_buttons;
    assign o_report.move_x  = r_move_x;
    assign o_report.move_y  = r_move_y;
    assign o_report.last    = r_last;

endmodule

FILE: rtl/core/gyro_to_mouse_report.sv
// ----------------------------------------------------------------------------
// gyro_to_mouse_report
// An item's motion report passes from the sample register through the curve
// product register into the report register; its null report follows once
// the sink takes it. Each item after calibration gives two reports on the
// single report port; new items can be taken while older ones are in flight.
// Calibration items are always accepted. Reset: deadband 2, curve offset 37,
// calibration restarts, and the first CAL_SAMPLES items produce no reports.
// ----------------------------------------------------------------------------
module gyro_to_mouse_report #(
    parameter int CAL_SAMPLES = gtm_pkg::CAL_SAMPLES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    gtm_sample_if.sink                      i_sample,
    gtm_report_if.source                    o_report,
    input  logic                            i_cfg_we,
    input  logic [gtm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gtm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import gtm_pkg::*;

    logic [DEADBAND_W-1:0] r_deadband;
    logic [OFFSET_W-1:0]   r_curve_offset;

    logic                  r_v1;
    logic [SAMPLE_W-1:0]   r_sx;
    logic [SAMPLE_W-1:0]   r_sy;
    logic [BTN_W-1:0]      r_btn1;
    logic                  r_v2;
    logic [BTN_W-1:0]      r_btn2;

    logic [SAMPLE_W-1:0]   w_sx;
    logic [SAMPLE_W-1:0]   w_sy;
    logic                  w_accept;
    logic                  w_cal_done;
    logic [SAMPLE_W-1:0]   w_x_base;
    logic [SAMPLE_W-1:0]   w_y_base;
    logic                  w_adv1;
    logic                  w_adv2;
    t_motion               w_motion;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband     <= DEADBAND_RESET;
            r_curve_offset <= CURVE_OFFSET_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_DEADBAND:     r_deadband     <= i_cfg_data[DEADBAND_W-1:0];
                CFG_CURVE_OFFSET: r_curve_offset <= i_cfg_data[OFFSET_W-1:0];
            endcase
        end
    end

    assign w_sx = scale_sample(i_sample.x_sample);
    assign w_sy = scale_sample(i_sample.y_sample);

    assign w_adv1         = r_v1 && (!r_v2 || w_adv2);
    assign i_sample.ready = !r_v1 || w_adv1;
    assign w_accept       = i_sample.valid && i_sample.ready;

    gtm_calib #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_calib (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_x_scaled   (w_sx),
        .i_y_scaled   (w_sy),
        .o_cal_done   (w_cal_done),
        .o_x_baseline (w_x_base),
        .o_y_baseline (w_y_base)
    );

    // calibration items are consumed without entering the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_accept && w_cal_done) begin
                r_v1 <= 1'b1;
            end else if (w_adv1) begin
                r_v1 <= 1'b0;
            end
            if (w_adv1) begin
                r_v2 <= 1'b1;
            end else if (w_adv2) begin
                r_v2 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sx   <= w_sx;
            r_sy   <= w_sy;
            r_btn1 <= {~i_sample.right_pin, ~i_sample.left_pin};
        end
        if (w_adv1) begin
            r_btn2 <= r_btn1;
        end
    end

    gtm_axis_curve u_axis_x (
        .i_clk          (i_clk),
        .i_ld           (w_adv1),
        .i_minuend      (r_sx),
        .i_subtrahend   (w_x_base),
        .i_deadband     (r_deadband),
        .i_curve_offset (r_curve_offset),
        .o_move         (w_motion.move_x)
    );

    // Y is reported negated: baseline minus sample
    gtm_axis_curve u_axis_y (
        .i_clk          (i_clk),
        .i_ld           (w_adv1),
        .i_minuend      (w_y_base),
        .i_subtrahend   (r_sy),
        .i_deadband     (r_deadband),
        .i_curve_offset (r_curve_offset),
        .o_move         (w_motion.move_y)
    );

    assign w_motion.buttons = r_btn2;

    gtm_report u_report (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v2),
        .i_motion (w_motion),
        .o_take   (w_adv2),
        .o_report (o_report)
    );

`ifndef NO_ASSERTIONS
    a_null_follows_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_report.valid && o_report.ready && !o_report.last
        |=> o_report.valid && o_report.last)
        else $error("null report did not follow motion report");

    a_null_keeps_buttons: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_report.valid && o_report.ready && !o_report.last
        |=> o_report.buttons == $past(o_report.buttons))
        else $error("null report buttons differ from motion report");

    a_empty_during_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_cal_done |-> !r_v1 && !r_v2)
        else $error("item in pipeline before calibration finished");
`endif

endmodule

FILE: sim/tb_gyro_to_mouse_report.sv
// ----------------------------------------------------------------------------
// tb_gyro_to_mouse_report
// Self-checking bench for the gyro to mouse report block. Drives raw gyro
// samples through the sample channel under random source gaps and sink
// stalls. Predicts calibration, baselines and the acceleration curve
// independently, and checks every report, field by field, in order.
// ----------------------------------------------------------------------------
module tb_gyro_to_mouse_report;
    timeunit 1ns;
    timeprecision 1ps;

    import gtm_pkg::*;

    localparam int CAL_N         = CAL_SAMPLES_DEF;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 150;
    localparam int PHASE_ITEMS   = 380;

    typedef struct packed {
        logic [SAMPLE_W-1:0] x;
        logic [SAMPLE_W-1:0] y;
        logic                left_pin;
        logic                right_pin;
    } t_gyro_sample;

    typedef struct packed {
        logic [BTN_W-1:0]         buttons;
        logic signed [MOVE_W-1:0] move_x;
        logic signed [MOVE_W-1:0] move_y;
        logic                     last;
    } t_mouse_report;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gtm_sample_if sample_ch ();
    gtm_report_if report_ch ();

    gyro_to_mouse_report i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (sample_ch),
        .o_report    (report_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor state
    logic [DEADBAND_W-1:0] deadband_q;
    logic [OFFSET_W-1:0]   offset_q;
    logic [SAMPLE_W-1:0]   x_base;
    logic [SAMPLE_W-1:0]   y_base;
    int                    x_sum;
    int                    y_sum;
    int                    cal_seen;

    t_mouse_report expected_reports[$];

    int errors          = 0;
    int samples_sent    = 0;
    int reports_checked = 0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;

    // Sink hold-off handshake between the test sequence and the ready process
    logic hold_req  = 1'b0;
    logic hold_ack  = 1'b0;
    int   hold_left = 0;

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack       <= hold_req;
            hold_left      <= HOLD_CYCLES - 1;
            report_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left      <= hold_left - 1;
            report_ch.ready <= 1'b0;
        end else begin
            report_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic logic [SAMPLE_W-1:0] scaled_reading(input logic [SAMPLE_W-1:0] v);
        int s;
        s = (int'(v) * 255) / 171;
        return (s > 255) ? 8'hFF : SAMPLE_W'(s);
    endfunction

    function automatic logic signed [MOVE_W-1:0] accel_curve(input int d);
        int mag;
        int q;
        mag = (d < 0) ? -d : d;
        if (mag <= int'(deadband_q))
            return '0;
        q = (d * ((3 * mag) / 2 + int'(offset_q))) / 80;
        if (q > 127)
            q = 127;
        if (q < -128)
            q = -128;
        return MOVE_W'(q);
    endfunction

    // Raw reading close to the one that maps onto a given scaled baseline
    function automatic logic [SAMPLE_W-1:0] raw_near(input logic [SAMPLE_W-1:0] base,
                                                     input int offs);
        int c;
        c = (int'(base) * 171) / 255 + offs;
        if (c < 0)
            c = 0;
        if (c > 255)
            c = 255;
        return SAMPLE_W'(c);
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_reading(input logic [SAMPLE_W-1:0] base);
        if ($urandom_range(0, 9) < 6)
            return raw_near(base, int'($urandom_range(0, 24)) - 12);
        return SAMPLE_W'($urandom_range(0, 255));
    endfunction

    function automatic t_gyro_sample random_sample();
        t_gyro_sample s;
        s.x         = random_reading(x_base);
        s.y         = random_reading(y_base);
        s.left_pin  = 1'($urandom_range(0, 1));
        s.right_pin = 1'($urandom_range(0, 1));
        return s;
    endfunction

    task automatic predict_reports(input t_gyro_sample s);
        logic [SAMPLE_W-1:0] sx;
        logic [SAMPLE_W-1:0] sy;
        t_mouse_report       r;
        sx = scaled_reading(s.x);
        sy = scaled_reading(s.y);
        if (cal_seen < CAL_N) begin
            x_sum    += int'(sx);
            y_sum    += int'(sy);
            cal_seen += 1;
            if (cal_seen == CAL_N) begin
                x_base = SAMPLE_W'(x_sum / CAL_N);
                y_base = SAMPLE_W'(y_sum / CAL_N);
            end
        end else begin
            r.buttons = {~s.right_pin, ~s.left_pin};
            r.move_x  = accel_curve(int'(sx) - int'(x_base));
            r.move_y  = accel_curve(int'(y_base) - int'(sy));
            r.last    = 1'b0;
            expected_reports.push_back(r);
            r.move_x  = '0;
            r.move_y  = '0;
            r.last    = 1'b1;
            expected_reports.push_back(r);
        end
    endtask

    // Leaves valid high after acceptance; the next call may lower it, a drain does
    task automatic send_sample(input t_gyro_sample s);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            sample_ch.valid    <= 1'b0;
            sample_ch.x_sample <= SAMPLE_W'($urandom_range(0, 255));
            sample_ch.y_sample <= SAMPLE_W'($urandom_range(0, 255));
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.x_sample  <= s.x;
        sample_ch.y_sample  <= s.y;
        sample_ch.left_pin  <= s.left_pin;
        sample_ch.right_pin <= s.right_pin;
        do @(posedge i_clk); while (!sample_ch.ready);
        predict_reports(s);
        samples_sent++;
    endtask

    task automatic drain_reports();
        sample_ch.valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both curve registers; only called with nothing in flight
    task automatic load_curve(input logic [CFG_DATA_W-1:0] db_data,
                              input logic [CFG_DATA_W-1:0] off_data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DEADBAND;
        i_cfg_data  <= db_data;
        @(posedge i_clk);
        i_cfg_index <= CFG_CURVE_OFFSET;
        i_cfg_data  <= off_data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        deadband_q = db_data[DEADBAND_W-1:0];
        offset_q   = off_data[OFFSET_W-1:0];
    endtask

    task automatic test_reset_write();
        // upper data bits set: deadband must mask them off
        load_curve(8'hF2, 8'd37);
    endtask

    task automatic test_calibration();
        logic [SAMPLE_W-1:0] cal_x [CAL_N] = '{8'd0, 8'd255, 8'd171, 8'd172, 8'd1, 8'd254,
                                               8'd128, 8'd127, 8'd100, 8'd200, 8'd50,
                                               8'd150, 8'd85, 8'd170, 8'd60, 8'd240};
        t_gyro_sample s;
        for (int i = 0; i < CAL_N; i++) begin
            s.x         = cal_x[i];
            s.y         = cal_x[CAL_N - 1 - i] ^ 8'h15;
            s.left_pin  = 1'($urandom_range(0, 1));
            s.right_pin = 1'($urandom_range(0, 1));
            send_sample(s);
        end
        drain_reports();
    endtask

    task automatic test_extreme_readings();
        t_gyro_sample s;
        send_sample('{8'd0,   8'd0,   1'b1, 1'b1});
        send_sample('{8'd255, 8'd255, 1'b0, 1'b0});
        send_sample('{8'd171, 8'd172, 1'b0, 1'b1});
        send_sample('{8'd172, 8'd171, 1'b1, 1'b0});
        send_sample('{8'd0,   8'd255, 1'b1, 1'b1});
        send_sample('{8'd255, 8'd0,   1'b0, 1'b0});
        // sweep across the deadband edges around the baselines
        for (int k = -2; k <= 2; k++) begin
            s.x         = raw_near(x_base, k);
            s.y         = raw_near(y_base, -k);
            s.left_pin  = 1'(k & 1);
            s.right_pin = 1'((k >> 1) & 1);
            send_sample(s);
        end
        drain_reports();
    endtask

    task automatic test_curve_extremes();
        logic [CFG_DATA_W-1:0] db_set  [3] = '{8'd0, 8'd15, 8'hF7};
        logic [CFG_DATA_W-1:0] off_set [3] = '{8'd0, 8'd255, 8'd128};
        for (int c = 0; c < 3; c++) begin
            load_curve(db_set[c], off_set[c]);
            repeat (40) send_sample(random_sample());
            drain_reports();
        end
    endtask

    task automatic test_random_traffic();
        int src_idle [3] = '{24, 74, 0};
        int snk_idle [3] = '{74, 24, 0};
        for (int p = 0; p < 3; p++) begin
            load_curve(CFG_DATA_W'($urandom_range(0, 255)), CFG_DATA_W'($urandom_range(0, 255)));
            send_idle_pct = src_idle[p];
            recv_idle_pct = snk_idle[p];
            repeat (PHASE_ITEMS) send_sample(random_sample());
            drain_reports();
        end
        load_curve(8'd2, 8'd37);
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req <= ~hold_req;
        repeat (24) send_sample(random_sample());
        drain_reports();
    endtask

    task automatic test_drain_pause();
        repeat (15) send_sample(random_sample());
        // hold the source until every pending report is out
        drain_reports();
        repeat (15) send_sample(random_sample());
        drain_reports();
    endtask

    always @(posedge i_clk) begin : check_reports
        t_mouse_report want;
        if (i_rst_n && report_ch.valid && report_ch.ready) begin
            if (expected_reports.size() == 0) begin
                $error("unexpected report: buttons %0d move_x %0d move_y %0d last %0b",
                       report_ch.buttons, report_ch.move_x, report_ch.move_y,
                       report_ch.last);
                errors++;
            end else begin
                want = expected_reports.pop_front();
                reports_checked++;
                if (report_ch.buttons !== want.buttons) begin
                    $error("buttons: expected %0d, actual %0d", want.buttons,
                           report_ch.buttons);
                    errors++;
                end
                if (report_ch.move_x !== want.move_x) begin
                    $error("move_x: expected %0d, actual %0d", want.move_x,
                           report_ch.move_x);
                    errors++;
                end
                if (report_ch.move_y !== want.move_y) begin
                    $error("move_y: expected %0d, actual %0d", want.move_y,
                           report_ch.move_y);
                    errors++;
                end
                if (report_ch.last !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, report_ch.last);
                    errors++;
                end
            end
        end
    end

    initial begin
        #(5_000_000);
        $display("simulation failed");
        $finish;
    end

    initial begin
        int waited;
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_index         <= CFG_DEADBAND;
        i_cfg_data          <= '0;
        sample_ch.valid     <= 1'b0;
        sample_ch.x_sample  <= '0;
        sample_ch.y_sample  <= '0;
        sample_ch.left_pin  <= 1'b1;
        sample_ch.right_pin <= 1'b1;
        deadband_q = DEADBAND_RESET;
        offset_q   = CURVE_OFFSET_RESET;
        x_base     = '0;
        y_base     = '0;
        x_sum      = 0;
        y_sum      = 0;
        cal_seen   = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_write();
        test_calibration();
        test_extreme_readings();
        test_curve_extremes();
        test_random_traffic();
        test_output_backpressure();
        test_drain_pause();

        sample_ch.valid <= 1'b0;
        waited = 0;
        while (expected_reports.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_reports.size() != 0) begin
            $error("%0d expected reports never arrived", expected_reports.size());
            errors += expected_reports.size();
        end

        $display("covered %0d samples (%0d calibration) and %0d checked reports,",
                 samples_sent, CAL_N, reports_checked);
        $display("with curve register extremes, sink back-pressure and a source pause");
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
